>>> design/gmnc_pkg.sv
// ----------------------------------------------------------------------------
// gmnc_pkg: shared types and constants for the mine neighbor counter
// Grid limits, register indexes, pipeline word and result formats.
// ----------------------------------------------------------------------------
package gmnc_pkg;

  localparam int MAX_COLS   = 1024;
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int COLS_CFG_W = 11;
  localparam int ROW_W      = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CNT_W      = 4;
  localparam int OUT_DATA_W = 8;
  localparam int IN_DATA_W  = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_COLS = 1'b0,
    REG_GRID_ROWS = 1'b1
  } reg_idx_e;

  // one accepted word with its position flags, held in the window stage
  typedef struct packed {
    logic             cur;     // mine bit after masking
    logic             p_ge1;
    logic             p_ge2;
    logic             p_last;  // drain row: reported row is the last grid row
    logic             c_zero;
    logic             c_last;
    logic [COL_W-1:0] col;
  } item_t;

  typedef struct packed {
    logic             last_in_run;
    logic             end_of_grid;
    logic             end_of_row;
    logic [CNT_W-1:0] neighbor_count;
    logic             is_mine;
  } result_t;

  function automatic logic [1:0] pop3(input logic [2:0] x);
    pop3 = {1'b0, x[0]} + {1'b0, x[1]} + {1'b0, x[2]};
  endfunction

endpackage

>>> design/gmnc_row_mem.sv
// ----------------------------------------------------------------------------
// gmnc_row_mem: two-row line store
// One write and one registered read per cycle, with write-to-read forwarding.
// ----------------------------------------------------------------------------
module gmnc_row_mem (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rd_en_i,
  input  logic [gmnc_pkg::COL_W-1:0] rd_addr_i,
  input  logic                      wr_en_i,
  input  logic [gmnc_pkg::COL_W-1:0] wr_addr_i,
  input  logic [1:0]                wr_data_i,
  output logic [1:0]                rd_data_o
);

  logic [1:0] mem [gmnc_pkg::MAX_COLS];
  logic [1:0] rd_q;
  logic [1:0] byp_data_q;
  logic       byp_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q       <= mem[rd_addr_i];
      byp_data_q <= wr_data_i;
    end
  end

  // forward a write that lands on the address read in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (rd_en_i) begin
      byp_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = byp_q ? byp_data_q : rd_q;

endmodule

>>> design/gmnc_window.sv
// ----------------------------------------------------------------------------
// gmnc_window: 3x3 window stage
// Holds one word, forms the new window column and counts neighbor mines.
// ----------------------------------------------------------------------------
module gmnc_window (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       clr_i,
  input  logic                       in_valid_i,
  input  gmnc_pkg::item_t            item_i,
  output logic                       ready_o,
  input  logic [1:0]                 rd_data_i,
  input  logic [1:0]                 space_i,
  output logic                       wr_en_o,
  output logic [gmnc_pkg::COL_W-1:0] wr_addr_o,
  output logic [1:0]                 wr_data_o,
  output logic [1:0]                 push_n_o,
  output gmnc_pkg::result_t          res0_o,
  output gmnc_pkg::result_t          res1_o
);

  gmnc_pkg::item_t   item_q;
  logic              valid_q;
  logic [5:0]        window_q;
  logic [5:0]        window_d;
  logic [5:0]        win;
  logic [2:0]        col3;
  logic              up;
  logic              mid;
  logic              emit0;
  logic              emit1;
  logic [1:0]        n;
  logic              adv;
  logic [3:0]        sum0;
  logic [3:0]        sum1;
  gmnc_pkg::result_t r0;
  gmnc_pkg::result_t r1;

  always_comb begin
    up    = item_q.p_ge2 & rd_data_i[1];
    mid   = item_q.p_ge1 & rd_data_i[0];
    col3  = {up, mid, item_q.cur};
    win   = item_q.c_zero ? 6'd0 : window_q;
    emit0 = item_q.p_ge1 & ~item_q.c_zero;
    emit1 = item_q.p_ge1 & item_q.c_last;
    n     = {1'b0, emit0} + {1'b0, emit1};
    adv   = valid_q && (n <= space_i);

    sum0 = {2'b00, gmnc_pkg::pop3(win[5:3])} + {2'b00, gmnc_pkg::pop3(win[2:0])}
         + {2'b00, gmnc_pkg::pop3(col3)};
    sum1 = {2'b00, gmnc_pkg::pop3(win[2:0])} + {2'b00, gmnc_pkg::pop3(col3)};

    r0.is_mine        = win[1];
    r0.neighbor_count = win[1] ? 4'd0 : sum0;
    r0.end_of_row     = 1'b0;
    r0.end_of_grid    = 1'b0;
    r0.last_in_run    = ~emit1;

    r1.is_mine        = col3[1];
    r1.neighbor_count = col3[1] ? 4'd0 : sum1;
    r1.end_of_row     = 1'b1;
    r1.end_of_grid    = item_q.p_last;
    r1.last_in_run    = 1'b1;

    window_d = {win[2:0], col3};
  end

  assign ready_o   = !valid_q || adv;
  assign wr_en_o   = adv;
  assign wr_addr_o = item_q.col;
  assign wr_data_o = {mid, item_q.cur};
  assign push_n_o  = adv ? n : 2'd0;
  assign res0_o    = emit0 ? r0 : r1;
  assign res1_o    = r1;

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      item_q <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      window_q <= 6'd0;
    end else begin
      if (in_valid_i) begin
        valid_q <= 1'b1;
      end else if (adv) begin
        valid_q <= 1'b0;
      end
      if (clr_i) begin
        window_q <= 6'd0;
      end else if (adv) begin
        window_q <= window_d;
      end
    end
  end

endmodule

>>> design/gmnc_out_fifo.sv
// ----------------------------------------------------------------------------
// gmnc_out_fifo: two-entry result buffer
// Takes one or two results per cycle and sends one word per cycle while the output is ready.
// ----------------------------------------------------------------------------
module gmnc_out_fifo (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [1:0]                          push_n_i,
  input  gmnc_pkg::result_t                   res0_i,
  input  gmnc_pkg::result_t                   res1_i,
  output logic [1:0]                          space_o,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [gmnc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tlast
);

  gmnc_pkg::result_t slot_q [2];
  gmnc_pkg::result_t slot_d [2];
  logic [1:0]        count_q;
  logic [1:0]        count_d;
  logic [1:0]        cnt;
  logic              pop;

  always_comb begin
    pop       = (count_q != 2'd0) && m_axis_tready;
    slot_d[0] = slot_q[0];
    slot_d[1] = slot_q[1];
    cnt       = count_q;
    if (pop) begin
      slot_d[0] = slot_q[1];
      cnt       = count_q - 2'd1;
    end
    case (push_n_i)
      2'd1: slot_d[cnt[0]] = res0_i;
      2'd2: begin
        slot_d[0] = res0_i;
        slot_d[1] = res1_i;
      end
      default: ;
    endcase
    count_d = cnt + push_n_i;
  end

  always_ff @(posedge clk_i) begin
    slot_q[0] <= slot_d[0];
    slot_q[1] <= slot_d[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  assign space_o       = 2'd2 - count_q;
  assign m_axis_tvalid = count_q != 2'd0;
  assign m_axis_tlast  = slot_q[0].last_in_run;
  assign m_axis_tdata  = {1'b0, slot_q[0].end_of_grid, slot_q[0].end_of_row,
                          slot_q[0].neighbor_count, slot_q[0].is_mine};

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("result buffer overfilled");
`endif

endmodule

>>> design/grid_mine_neighbor_count.sv
// A cell's result is formed in the window stage from the word at (r+1,c+1), a
// last-column cell's from the word at (r+1,c); it then waits in the result buffer.
// Throughput: one word per cycle while the result buffer has room; a row end yields
// two results and stalls input while the two-entry result buffer drains to the output.
// Reset clears positions, window and buffer; grid_cols and grid_rows reset to 1.
// The line store is not cleared; rows above the grid are masked on read.
// ----------------------------------------------------------------------------
// grid_mine_neighbor_count: streaming minesweeper neighbor counter
// Raster cell stream in, per-cell mine flag and neighbor count out.
// ----------------------------------------------------------------------------
module grid_mine_neighbor_count (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [gmnc_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // [0] cell_is_mine
  input  logic                                s_axis_tuser,  // [0] mode
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] is_mine, [4:1] neighbor_count, [5] end_of_row, [6] end_of_grid
  output logic [gmnc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tlast,  // last_in_run
  input  logic                                cfg_we_i,
  input  logic [gmnc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [gmnc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  logic [gmnc_pkg::COLS_CFG_W-1:0] grid_cols_q;
  logic [gmnc_pkg::ROW_W-1:0]      grid_rows_q;
  logic [gmnc_pkg::COLS_CFG_W-1:0] cols_eff;
  logic [gmnc_pkg::ROW_W-1:0]      rows_eff;
  logic [gmnc_pkg::COL_W-1:0]      col_last;
  logic [gmnc_pkg::COL_W-1:0]      col_q;
  logic [gmnc_pkg::ROW_W-1:0]      row_q;
  logic                            accept;
  gmnc_pkg::item_t                 item;
  logic [1:0]                      rd_data;
  logic                            wr_en;
  logic [gmnc_pkg::COL_W-1:0]      wr_addr;
  logic [1:0]                      wr_data;
  logic [1:0]                      space;
  logic [1:0]                      push_n;
  gmnc_pkg::result_t               res0;
  gmnc_pkg::result_t               res1;

  // clamp register values to the usable range
  always_comb begin
    if (grid_cols_q == '0) begin
      cols_eff = gmnc_pkg::COLS_CFG_W'(1);
    end else if (grid_cols_q > gmnc_pkg::COLS_CFG_W'(gmnc_pkg::MAX_COLS)) begin
      cols_eff = gmnc_pkg::COLS_CFG_W'(gmnc_pkg::MAX_COLS);
    end else begin
      cols_eff = grid_cols_q;
    end
    rows_eff = (grid_rows_q == '0) ? gmnc_pkg::ROW_W'(1) : grid_rows_q;
    col_last = gmnc_pkg::COL_W'(cols_eff - gmnc_pkg::COLS_CFG_W'(1));
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    item.cur    = !s_axis_tuser && (row_q < rows_eff) && s_axis_tdata[0];
    item.p_ge1  = row_q != '0;
    item.p_ge2  = row_q > gmnc_pkg::ROW_W'(1);
    item.p_last = row_q == rows_eff;
    item.c_zero = col_q == '0;
    item.c_last = col_q == col_last;
    item.col    = col_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_cols_q <= gmnc_pkg::COLS_CFG_W'(1);
      grid_rows_q <= gmnc_pkg::ROW_W'(1);
      col_q       <= '0;
      row_q       <= '0;
    end else if (cfg_we_i) begin
      unique case (gmnc_pkg::reg_idx_e'(cfg_idx_i))
        gmnc_pkg::REG_GRID_COLS: grid_cols_q <= cfg_wdata_i[gmnc_pkg::COLS_CFG_W-1:0];
        gmnc_pkg::REG_GRID_ROWS: grid_rows_q <= cfg_wdata_i;
        default: ;
      endcase
      // restart the stream
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (col_q == col_last) begin
        col_q <= '0;
        row_q <= (row_q >= rows_eff) ? '0 : row_q + gmnc_pkg::ROW_W'(1);
      end else begin
        col_q <= col_q + gmnc_pkg::COL_W'(1);
      end
    end
  end

  gmnc_row_mem u_row_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  gmnc_window u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_i      (cfg_we_i),
    .in_valid_i (accept),
    .item_i     (item),
    .ready_o    (s_axis_tready),
    .rd_data_i  (rd_data),
    .space_i    (space),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .push_n_o   (push_n),
    .res0_o     (res0),
    .res1_o     (res1)
  );

  gmnc_out_fifo u_out_fifo (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_n_i      (push_n),
    .res0_i        (res0),
    .res1_i        (res1),
    .space_o       (space),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

`ifndef SYNTH
  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (col_q == '0) && (row_q == '0))
    else $error("stream position not cleared by register write");
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(cfg_we_i) |-> ({1'b0, col_q} < cols_eff))
    else $error("column position beyond row length");
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(cfg_we_i) |-> (row_q <= rows_eff))
    else $error("row position beyond drain row");
`endif

endmodule

>>> dv/mine_count_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mine_count_checker: result predictor and comparator for the neighbor counter
// Watches the cell stream, the result stream and the register port, keeps its
// own copy of the line store and 3x3 window, and compares every result word
// field by field with the oldest predicted cell.
// ----------------------------------------------------------------------------
module mine_count_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [gmnc_pkg::IN_DATA_W-1:0]  in_data_i,   // [0] cell_is_mine
  input  logic                            in_user_i,   // [0] mode
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  // [0] is_mine, [4:1] neighbor_count, [5] end_of_row, [6] end_of_grid
  input  logic [gmnc_pkg::OUT_DATA_W-1:0] out_data_i,
  input  logic                            out_last_i,  // last_in_run
  input  logic                            cfg_we_i,
  input  logic [gmnc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gmnc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output int                              mismatch_count_o,
  output int                              pending_count_o
);

  logic [gmnc_pkg::COLS_CFG_W-1:0] cols_cfg;
  logic [gmnc_pkg::ROW_W-1:0]      rows_cfg;
  logic [1:0]                      line_mem [gmnc_pkg::MAX_COLS];
  logic [5:0]                      window;
  int                              row_pos;
  int                              col_pos;
  gmnc_pkg::result_t               expected_cells [$];
  int                              mismatches;

  task automatic push_cell(input logic [2:0] left, input logic [2:0] centre,
                           input logic [2:0] right, input int row, input int col,
                           input int rows, input int cols, input logic last);
    gmnc_pkg::result_t pred;
    int                mines;
    mines = $countones(left) + $countones(centre) + $countones(right) - centre[1];
    pred.is_mine        = centre[1];
    pred.neighbor_count = centre[1] ? '0 : mines[gmnc_pkg::CNT_W-1:0];
    pred.end_of_row     = (col == cols - 1);
    pred.end_of_grid    = pred.end_of_row && (row == rows - 1);
    pred.last_in_run    = last;
    expected_cells.push_back(pred);
  endtask

  // Shift one stream word into the window and queue the cells it completes.
  task automatic advance_window(input logic drain, input logic mine);
    int         cols;
    int         rows;
    int         p;
    int         c;
    logic [1:0] entry;
    logic [2:0] column;
    logic [5:0] prev;
    logic       cur;
    if (cols_cfg == 0) begin
      cols = 1;
    end else if (cols_cfg > gmnc_pkg::MAX_COLS) begin
      cols = gmnc_pkg::MAX_COLS;
    end else begin
      cols = int'(cols_cfg);
    end
    rows = (rows_cfg == 0) ? 1 : int'(rows_cfg);
    p = (row_pos > rows) ? 0 : row_pos;
    c = (col_pos >= cols) ? 0 : col_pos;
    // the drain row lies below the grid, so anything in it counts as empty
    cur = !drain && (p < rows) && mine;
    entry = line_mem[c];
    column = {(p >= 2) && entry[1], (p >= 1) && entry[0], cur};
    prev = (c == 0) ? '0 : window;
    if (p >= 1) begin
      if (c >= 1) begin
        push_cell(prev[5:3], prev[2:0], column, p - 1, c - 1, rows, cols,
                  c != cols - 1);
      end
      if (c == cols - 1) begin
        push_cell(prev[2:0], column, 3'b000, p - 1, c, rows, cols, 1'b1);
      end
    end
    line_mem[c] = column[1:0];
    window = {prev[2:0], column};
    if (c + 1 >= cols) begin
      col_pos = 0;
      row_pos = (p >= rows) ? 0 : p + 1;
    end else begin
      col_pos = c + 1;
      row_pos = p;
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    gmnc_pkg::result_t want;
    gmnc_pkg::result_t got;
    if (!rst_ni) begin
      cols_cfg = gmnc_pkg::COLS_CFG_W'(1);
      rows_cfg = gmnc_pkg::ROW_W'(1);
      window   = '0;
      row_pos  = 0;
      col_pos  = 0;
      foreach (line_mem[i]) line_mem[i] = '0;
      expected_cells.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      pending_count_o  <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = gmnc_pkg::result_t'({out_last_i, out_data_i[6:0]});
        if (expected_cells.size() == 0) begin
          $display("%0t: result word %02h tlast %0b arrived with no cell pending",
                   $time, out_data_i, out_last_i);
          mismatches++;
        end else begin
          want = expected_cells.pop_front();
          check_field("is_mine", want.is_mine, got.is_mine);
          check_field("neighbor_count", want.neighbor_count, got.neighbor_count);
          check_field("end_of_row", want.end_of_row, got.end_of_row);
          check_field("end_of_grid", want.end_of_grid, got.end_of_grid);
          check_field("last_in_run", want.last_in_run, got.last_in_run);
        end
      end
      // a register write restarts the stream; the line store is kept
      if (cfg_we_i) begin
        if (cfg_idx_i == gmnc_pkg::REG_GRID_COLS) begin
          cols_cfg = cfg_wdata_i[gmnc_pkg::COLS_CFG_W-1:0];
        end else begin
          rows_cfg = cfg_wdata_i[gmnc_pkg::ROW_W-1:0];
        end
        window  = '0;
        row_pos = 0;
        col_pos = 0;
      end
      if (in_valid_i && in_ready_i) begin
        advance_window(in_user_i, in_data_i[0]);
      end
      mismatch_count_o <= mismatches;
      pending_count_o  <= expected_cells.size();
    end
  end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the mine neighbor counter
// Streams directed and random grids with drain rows, rewrites the grid size
// between runs while idle, and throttles both stream sides at random.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int   HALF_PERIOD   = 10;
  localparam int   RESET_CYCLES  = 12;
  localparam int   SETTLE_CYCLES = 8;
  localparam int   DRAIN_CYCLES  = 20;
  localparam int   STALL_LIMIT   = 2000;
  localparam int   RANDOM_WORDS  = 360;
  localparam int   CELL_CAP      = 300;
  localparam logic MODE_CELL     = 1'b0;
  localparam logic MODE_DRAIN    = 1'b1;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [gmnc_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic                            s_axis_tuser;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [gmnc_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tlast;
  logic                            cfg_we;
  logic [gmnc_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [gmnc_pkg::CFG_DATA_W-1:0] cfg_wdata;

  int mismatches;
  int outstanding;
  int idle_cycles = 0;
  int rx_hold     = 0;
  int sent_words  = 0;
  int grid_cols   = 1;
  int grid_rows   = 1;
  bit tx_steady   = 1'b0;
  bit rx_steady   = 1'b0;

  grid_mine_neighbor_count i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata)
  );

  mine_count_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_i       (s_axis_tready),
    .in_data_i        (s_axis_tdata),
    .in_user_i        (s_axis_tuser),
    .out_valid_i      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_data_i       (m_axis_tdata),
    .out_last_i       (m_axis_tlast),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .mismatch_count_o (mismatches),
    .pending_count_o  (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #HALF_PERIOD clk_i = ~clk_i;
  end

  // mostly short pauses, now and then a long one
  function automatic int pick_gap(input int floor_len);
    if ($urandom_range(0, 99) < 90) return $urandom_range(floor_len, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
    end else if (rx_steady || $urandom_range(0, 3) != 0) begin
      m_axis_tready <= 1'b1;
      rx_hold       <= rx_steady ? 0 : $urandom_range(0, 5);
    end else begin
      m_axis_tready <= 1'b0;
      rx_hold       <= pick_gap(1);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int used_cols(input logic [gmnc_pkg::CFG_DATA_W-1:0] value);
    int n;
    n = value[gmnc_pkg::COLS_CFG_W-1:0];
    if (n == 0) return 1;
    if (n > gmnc_pkg::MAX_COLS) return gmnc_pkg::MAX_COLS;
    return n;
  endfunction

  // Hold valid high across back-to-back words; lower it only for a gap.
  task automatic send_word(input logic mode, input logic mine);
    int gap;
    gap = (tx_steady || $urandom_range(0, 1) == 0) ? 0 : pick_gap(1);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(gmnc_pkg::IN_DATA_W-1){1'b0}}, mine};
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_words++;
  endtask

  // Wait until every predicted cell is out, then write both size registers.
  task automatic set_grid(input logic [gmnc_pkg::CFG_DATA_W-1:0] cols_val,
                          input logic [gmnc_pkg::CFG_DATA_W-1:0] rows_val);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= gmnc_pkg::REG_GRID_COLS;
    cfg_wdata <= cols_val;
    @(posedge clk_i);
    cfg_idx   <= gmnc_pkg::REG_GRID_ROWS;
    cfg_wdata <= rows_val;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    grid_cols = used_cols(cols_val);
    grid_rows = (rows_val == 0) ? 1 : int'(rows_val);
  endtask

  // One grid plus its drain row, cut short after word_cap words.
  task automatic send_grid(input int mine_pct, input int noise_pct, input int word_cap);
    int   cells;
    int   i;
    logic mode;
    logic mine;
    cells = grid_cols * grid_rows;
    for (i = 0; i < cells + grid_cols && i < word_cap; i++) begin
      mode = (i >= cells) ? MODE_DRAIN : MODE_CELL;
      // flip the mode now and then: drain words in the grid, cells in the drain row
      if ($urandom_range(0, 99) < noise_pct) mode = ~mode;
      mine = (mode == MODE_DRAIN) ? 1'($urandom_range(0, 1))
                                  : ($urandom_range(0, 99) < mine_pct);
      send_word(mode, mine);
    end
  endtask

  initial begin
    int                              i;
    int                              g;
    int                              grids;
    int                              full;
    int                              cap;
    int                              budget;
    int                              roll;
    int                              mine_pct;
    int                              noise_pct;
    int                              start_words;
    logic [gmnc_pkg::CFG_DATA_W-1:0] cols_val;
    logic [gmnc_pkg::CFG_DATA_W-1:0] rows_val;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= MODE_CELL;
    cfg_we        <= 1'b0;
    cfg_idx       <= gmnc_pkg::REG_GRID_COLS;
    cfg_wdata     <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset size 1x1: a lone mine
    send_word(MODE_CELL, 1'b1);
    send_word(MODE_DRAIN, 1'b0);

    // zero sizes fall back to 1x1; a cell word in the drain row stays empty
    set_grid(16'd0, 16'd0);
    send_word(MODE_CELL, 1'b0);
    send_word(MODE_CELL, 1'b1);

    // ring of mines around an empty center: count of eight
    set_grid(16'd3, 16'd3);
    for (i = 0; i < 9; i++) send_word(MODE_CELL, i != 4);
    repeat (3) send_word(MODE_DRAIN, 1'($urandom_range(0, 1)));

    // drain word inside the grid counts as an empty cell
    set_grid(16'd2, 16'd1);
    send_word(MODE_DRAIN, 1'b1);
    send_word(MODE_CELL, 1'b1);
    send_word(MODE_DRAIN, 1'b0);
    send_word(MODE_DRAIN, 1'b1);

    // widest row through the clamp: the first results need the wrap at the
    // clamped width, then tallest grid cut short by a rewrite
    set_grid(16'hFFFF, 16'd1);
    send_grid(50, 0, grid_cols + 2);
    set_grid(16'hF803, 16'hFFFF);
    send_grid(30, 5, 40);

    start_words = sent_words;
    while (sent_words < start_words + RANDOM_WORDS) begin
      tx_steady = ($urandom_range(0, 4) == 0);
      rx_steady = ($urandom_range(0, 4) == 0);
      roll = $urandom_range(0, 9);
      if (roll < 7) begin
        cols_val = $urandom_range(1, 8);
      end else if (roll < 9) begin
        cols_val = $urandom_range(9, 40);
      end else begin
        cols_val = {5'($urandom_range(0, 31)), 11'($urandom_range(0, 6))};
      end
      roll = $urandom_range(0, 9);
      if (roll < 8) begin
        rows_val = $urandom_range(1, 6);
      end else if (roll < 9) begin
        rows_val = '0;
      end else begin
        rows_val = $urandom_range(7, 65535);
      end
      set_grid(cols_val, rows_val);
      grids     = $urandom_range(1, 3);
      mine_pct  = $urandom_range(0, 100);
      noise_pct = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
      for (g = 0; g < grids; g++) begin
        full = grid_cols * (grid_rows + 1);
        cap  = full;
        if (full > CELL_CAP) begin
          cap = $urandom_range(1, CELL_CAP);
        end else if (g == grids - 1 && $urandom_range(0, 6) == 0) begin
          cap = $urandom_range(1, full);
        end
        // stay within the word budget
        budget = start_words + RANDOM_WORDS - sent_words;
        if (cap > budget) cap = budget;
        send_grid(mine_pct, noise_pct, cap);
        if (cap < full) break;
      end
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
